@@ sv/rcsm_pkg.sv @@
// Package for the RC stick to setpoint mapper: payload structs, register
// indexes, fixed-point constants and controller/datapath command types.
`default_nettype none
package rcsm_pkg;

   localparam int AXIS_ONE   = 32768;
   localparam int QUOT_W     = 16;              // quotient bits before saturation
   localparam int NUM_W      = 13;              // |d| < 4096
   localparam int TICK_PERIOD_Q16 = 655;
   localparam int OFFSET_MIN = -131072;
   localparam int OFFSET_MAX = 131072;
   localparam int NUM_CH     = 4;

   typedef enum logic [2:0] {
      REG_CENTER     = 3'd0,
      REG_HALF_RANGE = 3'd1,
      REG_STICK_DZ   = 3'd2,
      REG_HOVER_DB   = 3'd3,
      REG_MAX_ROLL   = 3'd4,
      REG_MAX_PITCH  = 3'd5,
      REG_MAX_YAW    = 3'd6,
      REG_MAX_HOVER  = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [11:0] roll_us;
      logic [11:0] pitch_us;
      logic [11:0] yaw_us;
      logic [11:0] hover_us;
      logic        link_healthy;
      logic        failsafe_active;
      logic [31:0] sample_time_ms;
   } req_type;

   typedef struct packed {
      logic [31:0]        target_time_ms;
      logic signed [15:0] roll_target;
      logic signed [15:0] pitch_target;
      logic signed [15:0] yaw_rate_target;
      logic signed [15:0] hover_rate_target;
      logic signed [23:0] hover_offset;
      logic               target_valid;
   } rsp_type;

   typedef struct packed {
      logic [11:0] center_us;
      logic [10:0] half_range_us;
      logic [9:0]  stick_deadzone_us;
      logic [9:0]  hover_deadband_us;
      logic [14:0] max_roll;
      logic [14:0] max_pitch;
      logic [14:0] max_yaw_rate;
      logic [14:0] max_hover_rate;
   } cfg_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;       // capture request
      logic       setup;      // compute offset/span for channel ch
      logic       div_step;   // one restoring-division step
      logic       finish;     // saturate and multiply channel ch
      logic       integrate;  // update accumulator
      logic [1:0] ch;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic healthy;
   } stat_type;

endpackage
`default_nettype wire

@@ sv/rcsm_datapath.sv @@
// Datapath: input/config registers, one shared bit-serial divider, two
// multipliers and the height-offset integrator. Uses rcsm_pkg.
`default_nettype none
module rcsm_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rcsm_pkg::cfg_type cfg,
   input  wire rcsm_pkg::req_type req,
   input  wire rcsm_pkg::cmd_type cmd,
   output rcsm_pkg::stat_type     stat,
   output rcsm_pkg::rsp_type      result
);
   import rcsm_pkg::*;

   req_type                  req_ff;
   logic signed [15:0]       tgt_ff [NUM_CH];
   logic signed [23:0]       acc_ff, acc_in;
   // divider
   logic [NUM_W+QUOT_W-1:0]  num_ff, num_in;   // shifting dividend
   logic [11:0]              rem_ff, rem_in;
   logic [QUOT_W-1:0]        quo_ff, quo_in;
   logic [10:0]              den_ff;
   logic                     neg_ff;            // sign of result
   logic [1:0]               mode_ff;           // see MODE_ constants
   logic                     lo0_ff, hi0_ff;    // hover clamp sides

   localparam logic [1:0] MODE_ZERO = 2'd0, MODE_DIV = 2'd1, MODE_FULL = 2'd2;

   logic [11:0]        pulse;
   logic signed [13:0] d, dz, hspan, dnum;
   logic [12:0]        mag;
   logic [12:0]        trial;
   logic [16:0]        qmag;
   logic [16:0]        amag;
   logic [14:0]        maxv;
   logic [31:0]        prod;
   logic [15:0]        pmag;
   logic signed [31:0] dlt_prod;
   logic signed [31:0] delta;
   logic signed [31:0] sum;

   always_comb begin
      case (cmd.ch)
         2'd0:    pulse = req_ff.roll_us;
         2'd1:    pulse = req_ff.pitch_us;
         2'd2:    pulse = req_ff.yaw_us;
         default: pulse = req_ff.hover_us;
      endcase
      case (cmd.ch)
         2'd0:    maxv = cfg.max_roll;
         2'd1:    maxv = cfg.max_pitch;
         2'd2:    maxv = cfg.max_yaw_rate;
         default: maxv = cfg.max_hover_rate;
      endcase
      d     = $signed({2'b0, pulse}) - $signed({2'b0, cfg.center_us});
      dz    = (cmd.ch == 2'd3) ? $signed({4'b0, cfg.hover_deadband_us})
                               : $signed({4'b0, cfg.stick_deadzone_us});
      hspan = $signed({3'b0, cfg.half_range_us}) - $signed({4'b0, cfg.hover_deadband_us});
      if (cmd.ch != 2'd3)  dnum = d;
      else if (d > 0)      dnum = d - dz;
      else                 dnum = d + dz;
      mag   = dnum[13] ? 13'(-dnum) : 13'(dnum);
      trial = {rem_ff, num_ff[NUM_W+QUOT_W-1]};
      // saturate quotient to 32768
      qmag  = (quo_ff > 16'(AXIS_ONE)) ? 17'(AXIS_ONE) : {1'b0, quo_ff};
      case (mode_ff)
         MODE_DIV:  amag = qmag;
         MODE_FULL: amag = 17'(AXIS_ONE);
         default:   amag = 17'd0;
      endcase
      if ((neg_ff && lo0_ff) || (!neg_ff && hi0_ff)) amag = 17'd0;
      prod  = 32'(amag) * 32'(maxv);
      pmag  = 16'(prod >> 15);
      dlt_prod = 32'(tgt_ff[3]) * 32'(TICK_PERIOD_Q16);
      delta = dlt_prod / 32'sd4096;    // truncates toward zero
      sum   = 32'(acc_ff) + delta;
      if (sum < 32'(OFFSET_MIN))      acc_in = 24'(OFFSET_MIN);
      else if (sum > 32'(OFFSET_MAX)) acc_in = 24'(OFFSET_MAX);
      else                            acc_in = sum[23:0];
      num_in = num_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.setup) begin
         // dividend is |num| * 32768
         num_in = {1'b0, mag, {(QUOT_W-1){1'b0}}};
         rem_in = '0;
         quo_in = '0;
      end else if (cmd.div_step) begin
         num_in = num_ff << 1;
         if ({1'b0, trial} >= {3'b0, den_ff}) begin
            rem_in = 12'(trial - 13'(den_ff));
            quo_in = {quo_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in = trial[11:0];
            quo_in = {quo_ff[QUOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.integrate) begin
         acc_ff <= req_ff.link_healthy && !req_ff.failsafe_active ? acc_in : '0;
      end
      if (cmd.load) req_ff <= req;
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.setup) begin
         neg_ff <= d < 0;
         lo0_ff <= 1'b0;
         hi0_ff <= 1'b0;
         if (cmd.ch == 2'd3) begin
            den_ff <= hspan[10:0];
            lo0_ff <= d > dz;     // above band: clamp to [0,1]
            hi0_ff <= d < -dz;    // below band: clamp to [-1,0]
            if (d >= -dz && d <= dz) mode_ff <= MODE_ZERO;
            else if (hspan <= 0)     mode_ff <= MODE_FULL;
            // offset at or past the span saturates
            else if ({1'b0, mag} >= $unsigned(hspan)) mode_ff <= MODE_FULL;
            else                     mode_ff <= MODE_DIV;
            if (!(d >= -dz && d <= dz) && hspan <= 0) begin
               lo0_ff <= 1'b0;
               hi0_ff <= 1'b0;
            end
         end else begin
            den_ff <= cfg.half_range_us;
            if (d >= -dz && d <= dz)          mode_ff <= MODE_ZERO;
            else if (cfg.half_range_us == 0)  mode_ff <= MODE_FULL;
            else if ({1'b0, mag} >= {3'b0, cfg.half_range_us}) mode_ff <= MODE_FULL;
            else                              mode_ff <= MODE_DIV;
         end
      end
      if (cmd.finish) begin
         tgt_ff[cmd.ch]  <= neg_ff ? -$signed(pmag) : $signed(pmag);
      end
   end

   assign stat.healthy = req_ff.link_healthy && !req_ff.failsafe_active;

   always_comb begin
      result.target_time_ms    = req_ff.sample_time_ms;
      result.roll_target       = stat.healthy ? tgt_ff[0] : '0;
      result.pitch_target      = stat.healthy ? tgt_ff[1] : '0;
      result.yaw_rate_target   = stat.healthy ? tgt_ff[2] : '0;
      result.hover_rate_target = stat.healthy ? tgt_ff[3] : '0;
      result.hover_offset      = acc_ff;
      result.target_valid      = stat.healthy;
   end
endmodule
`default_nettype wire

@@ sv/rcsm_ctrl.sv @@
// Controller: sequences the four channels through setup, divide and finish,
// then the integrator, and holds the response handshake. Uses rcsm_pkg.
`default_nettype none
module rcsm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire rcsm_pkg::stat_type stat,
   output rcsm_pkg::cmd_type       cmd
);
   import rcsm_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_SETUP, S_DIV, S_FIN, S_INT, S_OUT} state_type;

   state_type  state_ff;
   logic [1:0] ch_ff;
   logic [4:0] cnt_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      cmd           = '0;
      cmd.ch        = ch_ff;
      cmd.load      = req_valid && req_ready;
      cmd.setup     = (state_ff == S_SETUP);
      cmd.div_step  = (state_ff == S_DIV);
      cmd.finish    = (state_ff == S_FIN);
      cmd.integrate = (state_ff == S_INT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ch_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) begin
               state_ff <= S_SETUP;
               ch_ff    <= '0;
            end
            S_SETUP: begin
               state_ff <= stat.healthy ? S_DIV : S_INT;
               cnt_ff   <= '0;
            end
            S_DIV: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(NUM_W + QUOT_W - 1)) state_ff <= S_FIN;
            end
            S_FIN: begin
               ch_ff <= ch_ff + 2'd1;
               state_ff <= (ch_ff == 2'(NUM_CH - 1)) ? S_INT : S_SETUP;
            end
            S_INT:   state_ff <= S_OUT;
            S_OUT:   if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ sv/rc_stick_to_setpoint_mapper_top.sv @@
// Top level of the RC stick to setpoint mapper: config registers, controller
// and datapath. Uses rcsm_pkg, rcsm_ctrl, rcsm_datapath.
//
//   channel  prefix  direction  payload
//   request  req_    in         rcsm_pkg::req_type
//   response rsp_    out        rcsm_pkg::rsp_type
//   config   csr_    in         3-bit index, 16-bit data
//
// A healthy request runs each channel through setup, 29 steps of one shared
// restoring divider and finish, then the integrator, before rsp_valid rises.
// Unhealthy requests skip the divider: setup, then integrate, then respond.
// One request at a time; the response holds until taken. Reset is synchronous
// and restores register defaults and clears the height offset.
`default_nettype none
module rc_stick_to_setpoint_mapper_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rcsm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rcsm_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [15:0]       csr_data
);
   import rcsm_pkg::*;

   cfg_type  cfg_ff;
   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_us         <= 12'd1500;
         cfg_ff.half_range_us     <= 11'd500;
         cfg_ff.stick_deadzone_us <= 10'd20;
         cfg_ff.hover_deadband_us <= 10'd50;
         cfg_ff.max_roll          <= 15'd2145;
         cfg_ff.max_pitch         <= 15'd2145;
         cfg_ff.max_yaw_rate      <= 15'd2880;
         cfg_ff.max_hover_rate    <= 15'd4096;
      end else if (csr_valid) begin
         case (reg_idx_type'(csr_index))
            REG_CENTER:     cfg_ff.center_us         <= csr_data[11:0];
            REG_HALF_RANGE: cfg_ff.half_range_us     <= csr_data[10:0];
            REG_STICK_DZ:   cfg_ff.stick_deadzone_us <= csr_data[9:0];
            REG_HOVER_DB:   cfg_ff.hover_deadband_us <= csr_data[9:0];
            REG_MAX_ROLL:   cfg_ff.max_roll          <= csr_data[14:0];
            REG_MAX_PITCH:  cfg_ff.max_pitch         <= csr_data[14:0];
            REG_MAX_YAW:    cfg_ff.max_yaw_rate      <= csr_data[14:0];
            REG_MAX_HOVER:  cfg_ff.max_hover_rate    <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   rcsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rcsm_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req_data),
      .cmd    (cmd),
      .stat   (stat),
      .result (rsp_data)
   );
endmodule
`default_nettype wire
